>>> design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and ring index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [VALUE_W-1:0]  value;
  } item_t;

  typedef struct packed {
    status_t                    status;
    logic [CNT_W-1:0]           count;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // run the request on the indices and the store
    logic load;  // merge read data and load the result register
  } ctl_cmd_t;

  // Add two ring indices, wrapping at DEPTH. Sum stays below 2*DEPTH.
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [ADDR_W-1:0] offset);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ring_dec(logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] idx;
    if (base == '0) begin
      idx = ADDR_W'(DEPTH - 1);
    end else begin
      idx = base - ADDR_W'(1);
    end
    return idx;
  endfunction

endpackage

>>> design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values with push/pop at either end.
// ----------------------------------------------------------------------------
// Each request pushes or pops one element at the front or the back of a ring
// of deq_pkg::DEPTH entries and returns one result: a status code, the count
// after the request, and the front and back values (zero when empty). A push
// on a full queue or a pop on an empty one is rejected with its status code
// and leaves the queue untouched. A request runs in two steps: on the accept
// edge the indices and count advance and the store is written or read, and
// in the load state the store's registered read data is merged into the
// result register. No new request is taken until that merge, since the
// element store reads into a register. The result register parts the two
// sides: a new request is taken while the previous result still waits, and
// a finished request holds in the sequencer until the result slot frees up.
// There is no clearing pass; only entries that hold queued elements are read.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  deq_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output deq_pkg::result_t result
);

  deq_pkg::ctl_cmd_t cmd;

  // Sequencer: owns the handshakes, issues execute and load commands.
  deq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // Datapath: ring indices, cached end values, store and result register.
  deq_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

`ifndef SYNTH
  // An accepted request blocks the next one for at least its read cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while another is in flight");

  // Count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("count above depth");

  // Empty queue reports zero at both ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.count == '0 |->
      result.front_value == '0 && result.back_value == '0)
    else $error("empty queue reports nonzero end values");

  // A rejected push only happens on a full queue, a rejected pop on an empty one.
  a_reject_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.status != deq_pkg::ST_FULL ||
       result.count == deq_pkg::CNT_W'(deq_pkg::DEPTH)) &&
      (result.status != deq_pkg::ST_EMPTY || result.count == '0))
    else $error("reject status does not match count");
`endif

endmodule

>>> design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: accept, wait for the store read, hand off the result.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output deq_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // Output slot is free when empty or being drained this cycle.
  assign slot_free  = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.exec   = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.exec   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Queue datapath: ring indices, cached end values, element store, result.
// ----------------------------------------------------------------------------
module deq_dp (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::ctl_cmd_t cmd,
  input  deq_pkg::item_t    item,
  output deq_pkg::result_t  result
);

  logic [deq_pkg::ADDR_W-1:0]         front_idx;
  logic [deq_pkg::ADDR_W-1:0]         front_idx_next;
  logic [deq_pkg::CNT_W-1:0]          count;
  logic [deq_pkg::CNT_W-1:0]          count_next;
  logic [deq_pkg::CNT_W-1:0]          count_m2;
  logic signed [deq_pkg::VALUE_W-1:0] front_val;
  logic signed [deq_pkg::VALUE_W-1:0] front_val_next;
  logic signed [deq_pkg::VALUE_W-1:0] back_val;
  logic signed [deq_pkg::VALUE_W-1:0] back_val_next;
  deq_pkg::status_t                   status_next;
  deq_pkg::status_t                   status_q;
  logic                               rd_front_next;
  logic                               rd_back_next;
  logic                               rd_front;
  logic                               rd_back;
  logic                               is_full;
  logic                               is_empty;
  logic                               wr_en;
  logic [deq_pkg::ADDR_W-1:0]         wr_addr;
  logic                               rd_en;
  logic [deq_pkg::ADDR_W-1:0]         rd_addr;
  logic [deq_pkg::VALUE_W-1:0]        rd_data;
  logic signed [deq_pkg::VALUE_W-1:0] front_out;
  logic signed [deq_pkg::VALUE_W-1:0] back_out;

  assign is_full  = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_empty = (count == '0);
  assign count_m2 = count - deq_pkg::CNT_W'(2);

  always_comb begin
    front_idx_next = front_idx;
    count_next     = count;
    front_val_next = front_val;
    back_val_next  = back_val;
    status_next    = deq_pkg::ST_DONE;
    rd_front_next  = 1'b0;
    rd_back_next   = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = deq_pkg::ring_dec(front_idx);
    rd_en          = 1'b0;
    rd_addr        = deq_pkg::ring_add(front_idx, deq_pkg::ADDR_W'(1));
    unique case (item.operation)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          front_idx_next = deq_pkg::ring_dec(front_idx);
          wr_en          = cmd.exec;
          count_next     = count + deq_pkg::CNT_W'(1);
          front_val_next = item.value;
          if (is_empty) begin
            back_val_next = item.value;
          end
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        wr_addr = deq_pkg::ring_add(front_idx, count[deq_pkg::ADDR_W-1:0]);
        if (is_full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          wr_en         = cmd.exec;
          count_next    = count + deq_pkg::CNT_W'(1);
          back_val_next = item.value;
          if (is_empty) begin
            front_val_next = item.value;
          end
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          front_idx_next = deq_pkg::ring_add(front_idx, deq_pkg::ADDR_W'(1));
          count_next     = count - deq_pkg::CNT_W'(1);
          if (count == deq_pkg::CNT_W'(1)) begin
            front_val_next = '0;
            back_val_next  = '0;
          end else begin
            rd_en         = cmd.exec;
            rd_front_next = 1'b1;
          end
        end
      end
      deq_pkg::OP_POP_BACK: begin
        rd_addr = deq_pkg::ring_add(front_idx, count_m2[deq_pkg::ADDR_W-1:0]);
        if (is_empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          count_next = count - deq_pkg::CNT_W'(1);
          if (count == deq_pkg::CNT_W'(1)) begin
            front_val_next = '0;
            back_val_next  = '0;
          end else begin
            rd_en        = cmd.exec;
            rd_back_next = 1'b1;
          end
        end
      end
      default: begin
        status_next = deq_pkg::ST_DONE;
      end
    endcase
  end

  deq_ram #(
    .WIDTH (deq_pkg::VALUE_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Merge the fresh read into the end that moved.
  assign front_out = rd_front ? $signed(rd_data) : front_val;
  assign back_out  = rd_back  ? $signed(rd_data) : back_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_idx <= '0;
      count     <= '0;
      front_val <= '0;
      back_val  <= '0;
    end else if (cmd.exec) begin
      front_idx <= front_idx_next;
      count     <= count_next;
      front_val <= front_val_next;
      back_val  <= back_val_next;
    end else if (cmd.load) begin
      front_val <= front_out;
      back_val  <= back_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_next;
      rd_front <= rd_front_next;
      rd_back  <= rd_back_next;
    end
    if (cmd.load) begin
      result.status      <= status_q;
      result.count       <= count;
      result.front_value <= front_out;
      result.back_value  <= back_out;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel with random gaps. A shadow
// deque, kept in the bench, predicts every result. A checker compares each
// result, field by field, with the oldest prediction while the result side
// stalls at random. The tests cover empty pops, value extremes, a random walk
// that hits empty often, a full fill from both ends with rejected pushes and
// index wrap, and random traffic around the full mark.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 120;
  localparam int CYCLE_LIMIT  = 100000;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  deq_pkg::item_t    item;
  logic              result_valid;
  logic              result_ready;
  deq_pkg::result_t  result;

  // Shadow of the queue: its own ring, front slot and element count.
  logic signed [deq_pkg::VALUE_W-1:0] shadow_ring [deq_pkg::DEPTH];
  int      shadow_front;
  int      shadow_held;

  deq_pkg::result_t pending_results [$];
  int      error_count;
  int      requests_sent;
  int      results_checked;
  int      full_rejects;
  int      empty_rejects;
  int      cycle_count;
  int      stall_left;
  bit      no_gaps;

  double_ended_queue u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the shadow deque and return the result it implies.
  function automatic deq_pkg::result_t predict_deque(
    deq_pkg::op_t op, logic signed [deq_pkg::VALUE_W-1:0] val);
    deq_pkg::result_t r;
    r = '0;
    r.status = deq_pkg::ST_DONE;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (shadow_held >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          shadow_ring[shadow_front] = val;
          shadow_held++;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (shadow_held >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_held) % deq_pkg::DEPTH] = val;
          shadow_held++;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (shadow_held == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % deq_pkg::DEPTH;
          shadow_held--;
        end
      end
      default: begin
        if (shadow_held == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_held--;
        end
      end
    endcase
    r.count = deq_pkg::CNT_W'(shadow_held);
    if (shadow_held != 0) begin
      r.front_value = shadow_ring[shadow_front];
      r.back_value  = shadow_ring[(shadow_front + shadow_held - 1) % deq_pkg::DEPTH];
    end
    return r;
  endfunction

  // Favor the extremes half the time; otherwise a full 32-bit random word.
  function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
    logic signed [deq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'sh7fff_ffff;
      1:       v = 32'sh8000_0000;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Push with probability push_pct percent, at a random end.
  function automatic deq_pkg::op_t pick_op(int push_pct);
    deq_pkg::op_t op;
    if ($urandom_range(0, 99) < push_pct) begin
      op = deq_pkg::op_t'($urandom_range(0, 1));
    end else begin
      op = deq_pkg::op_t'($urandom_range(2, 3));
    end
    return op;
  endfunction

  // Send one request: idle a random number of cycles, hold valid and the
  // payload until ready, then record the predicted result.
  task automatic send_request(deq_pkg::op_t op,
                              logic signed [deq_pkg::VALUE_W-1:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{operation: op, value: val};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_results = {pending_results, predict_deque(op, val)};
    requests_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pops on an empty queue must be rejected whatever the value field holds.
  task automatic test_empty_pops();
    send_request(deq_pkg::OP_POP_FRONT, 32'sh8000_0000);
    send_request(deq_pkg::OP_POP_BACK, 32'sh7fff_ffff);
    send_request(deq_pkg::OP_POP_FRONT, '1);
    send_request(deq_pkg::OP_POP_BACK, '0);
    release_input();
  endtask

  // Extremes at both ends, front wrap from slot zero, then drain to empty
  // and check that the reported values fall back to zero.
  task automatic test_basic_ops();
    send_request(deq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(deq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    send_request(deq_pkg::OP_PUSH_FRONT, '0);
    send_request(deq_pkg::OP_PUSH_BACK, '1);
    send_request(deq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    send_request(deq_pkg::OP_PUSH_BACK, 32'shaaaa_aaaa);
    send_request(deq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    send_request(deq_pkg::OP_POP_BACK, '0);
    send_request(deq_pkg::OP_POP_BACK, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    send_request(deq_pkg::OP_POP_BACK, '0);
    send_request(deq_pkg::OP_POP_BACK, '0);
    send_request(deq_pkg::OP_PUSH_BACK, 32'sh0000_0001);
    send_request(deq_pkg::OP_POP_FRONT, '0);
    release_input();
  endtask

  // Fill to capacity from both ends so the indices wrap, bounce pushes off
  // the full queue, then free one slot and refill it.
  task automatic test_full_queue();
    no_gaps = 1'b1;
    while (shadow_held < deq_pkg::DEPTH) begin
      send_request(deq_pkg::op_t'($urandom_range(0, 1)), pick_value());
    end
    no_gaps = 1'b0;
    send_request(deq_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(deq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    send_request(deq_pkg::OP_POP_BACK, '0);
    send_request(deq_pkg::OP_PUSH_BACK, pick_value());
    send_request(deq_pkg::OP_PUSH_FRONT, pick_value());
    send_request(deq_pkg::OP_POP_FRONT, pick_value());
    release_input();
  endtask

  // Random walk in segments, each with its own push bias and with or
  // without idle gaps, so the count roams and hits empty often.
  task automatic test_random_walk();
    int sent;
    int seg_len;
    int bias;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       bias = 80;
        1:       bias = 20;
        default: bias = 50;
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat (seg_len) begin
        send_request(pick_op(bias), pick_value());
        sent++;
      end
    end
    no_gaps = 1'b0;
    release_input();
  endtask

  // Random traffic around the full mark so rejected pushes mix with
  // accepted ones at both ends.
  task automatic test_random_near_full();
    no_gaps = 1'b1;
    while (shadow_held < deq_pkg::DEPTH - 3) begin
      send_request(deq_pkg::op_t'($urandom_range(0, 1)), pick_value());
    end
    no_gaps = 1'b0;
    repeat (40) send_request(pick_op(60), pick_value());
    release_input();
  endtask

  // Checker: compare each accepted result with the oldest prediction, then
  // draw the stall before the next result is taken.
  always @(posedge clk) begin
    deq_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d",
               result.status, result.count);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (want.status == deq_pkg::ST_FULL) full_rejects++;
        if (want.status == deq_pkg::ST_EMPTY) empty_rejects++;
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          error_count++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          error_count++;
        end
        if (result.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value,
                 result.front_value);
          error_count++;
        end
        if (result.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value,
                 result.back_value);
          error_count++;
        end
      end
      stall_left = no_gaps ? 0 : $urandom_range(0, 7);
    end
  end

  // Drive result_ready at the falling edge: hold low while a stall runs.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if it goes far beyond the slowest correct run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    item            = '0;
    stall_left      = 0;
    no_gaps         = 1'b0;
    error_count     = 0;
    requests_sent   = 0;
    results_checked = 0;
    full_rejects    = 0;
    empty_rejects   = 0;
    shadow_front    = 0;
    shadow_held     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_pops();
    test_basic_ops();
    test_random_walk();
    test_full_queue();
    test_random_near_full();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("summary: %0d requests sent, %0d results checked", requests_sent,
             results_checked);
    $display("summary: %0d full-queue and %0d empty-queue rejections seen",
             full_rejects, empty_rejects);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
